@@ hdl/gcd_lcm_by_factorization_macros.svh @@
// Assertion macros shared by the gcd/lcm block.
`ifndef GCD_LCM_BY_FACTORIZATION_MACROS_SVH
`define GCD_LCM_BY_FACTORIZATION_MACROS_SVH
`ifndef SYNTHESIS
`define GLA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gla assertion failed");
`define GLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gla assertion failed");
`else
`define GLA_ASSERT_SAME(lbl, ante, cons)
`define GLA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/gla_pkg.sv @@
// Types and constants of the gcd/lcm block.
package gla_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int MULT_BITS    = 2 * OPERAND_BITS;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS);
  localparam logic [OPERAND_BITS-1:0] MinValid = OPERAND_BITS'(2);
  localparam logic [CNT_BITS-1:0]     LastStep = CNT_BITS'(OPERAND_BITS - 1);

  typedef struct packed {
    logic [OPERAND_BITS-1:0] first_value;
    logic [OPERAND_BITS-1:0] second_value;
  } in_beat_t;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] common_divisor;
    logic [MULT_BITS-1:0]    common_multiple;
    logic                    input_error;
  } out_beat_t;

  typedef struct packed {
    logic [MULT_BITS-1:0] lhs;
    logic [MULT_BITS-1:0] rhs;
    logic                 sub;
  } alu_req_t;

  typedef struct packed {
    logic [MULT_BITS-1:0] sum;
    logic                 carry;
  } alu_rsp_t;

endpackage

@@ hdl/gcd_lcm_by_factorization.sv @@
// Top level: binary gcd, then lcm = (a / gcd) * b, all on one shared adder.
// Sequence: an operand below 2 goes straight to the finish state with the error
// flag set; otherwise the binary gcd, whose run depends on the operands, is
// followed by the division of a by the gcd, the multiply by b and the output load.
// Throughput: one item at a time; the input stalls until the result is loaded.
// Reset: rst_ni low clears the sequencer and the output valid at once.
`include "gcd_lcm_by_factorization_macros.svh"

module gcd_lcm_by_factorization (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gla_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gla_pkg::out_beat_t   out_data_o
);

  localparam int W  = gla_pkg::OPERAND_BITS;
  localparam int MW = gla_pkg::MULT_BITS;
  localparam int CW = gla_pkg::CNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVEN,
    S_REDUCE,
    S_DIV,
    S_MUL,
    S_FINISH
  } state_e;

  state_e             state_q;
  logic [W-1:0]       a_q, b_q, sa_q, sb_q, g_q;
  logic [CW-1:0]      k_q, cnt_q;
  logic [MW-1:0]      acc_q;
  logic               err_q;
  logic               out_valid_q;
  gla_pkg::out_beat_t out_data_q;

  gla_pkg::alu_req_t  alu_req;
  gla_pkg::alu_rsp_t  alu_rsp;
  logic               in_fire;
  logic [W:0]         div_shift;
  logic               q_bit;

  gla_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // remainder shifted left with the next numerator bit
  assign div_shift = {b_q, a_q[W-1]};
  assign q_bit     = alu_rsp.carry;

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_REDUCE: begin
        alu_req.lhs = MW'(a_q);
        alu_req.rhs = MW'(b_q);
        alu_req.sub = 1'b1;
      end
      S_DIV: begin
        alu_req.lhs = MW'(div_shift);
        alu_req.rhs = MW'(g_q);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.lhs = {acc_q[MW-2:0], 1'b0};
        alu_req.rhs = a_q[W-1] ? MW'(sb_q) : '0;
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      g_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // the finish state handles the output valid on its own
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data_i.first_value < gla_pkg::MinValid ||
                in_data_i.second_value < gla_pkg::MinValid) begin
              g_q     <= '0;
              acc_q   <= '0;
              err_q   <= 1'b1;
              state_q <= S_FINISH;
            end else begin
              a_q     <= in_data_i.first_value;
              b_q     <= in_data_i.second_value;
              sa_q    <= in_data_i.first_value;
              sb_q    <= in_data_i.second_value;
              k_q     <= '0;
              err_q   <= 1'b0;
              state_q <= S_EVEN;
            end
          end
        end
        S_EVEN: begin
          // strip common factors of two
          if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= k_q + CW'(1);
          end else begin
            state_q <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (a_q == '0 || b_q == '0) begin
            g_q     <= W'((a_q | b_q) << k_q);
            a_q     <= sa_q;
            b_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (alu_rsp.carry) begin
            a_q <= alu_rsp.sum[W-1:0];
          end else begin
            // a < b: swap so the next subtract is non-negative
            a_q <= b_q;
            b_q <= a_q;
          end
        end
        S_DIV: begin
          b_q <= q_bit ? alu_rsp.sum[W-1:0] : div_shift[W-1:0];
          a_q <= {a_q[W-2:0], q_bit};
          if (cnt_q == gla_pkg::LastStep) begin
            cnt_q   <= '0;
            acc_q   <= '0;
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_MUL: begin
          acc_q <= alu_rsp.sum;
          a_q   <= a_q << 1;
          if (cnt_q == gla_pkg::LastStep) begin
            state_q <= S_FINISH;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_data_q.common_divisor  <= g_q;
            out_data_q.common_multiple <= acc_q;
            out_data_q.input_error     <= err_q;
            out_valid_q                <= 1'b1;
            state_q                    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `GLA_ASSERT_SAME(a_reduce_odd, state_q == S_REDUCE, a_q[0] || b_q[0])
  `GLA_ASSERT_SAME(a_div_rem_below, state_q == S_DIV, (b_q < g_q))
  `GLA_ASSERT_SAME(a_err_zero, out_valid_o && out_data_o.input_error, (out_data_o.common_divisor == '0) && (out_data_o.common_multiple == '0))
  `GLA_ASSERT_SAME(a_ok_nonzero, out_valid_o && !out_data_o.input_error, (out_data_o.common_divisor != '0) && (out_data_o.common_multiple != '0))
  `GLA_ASSERT_NEXT(a_accept_busy, in_fire, state_q != S_IDLE)

endmodule

@@ hdl/gla_alu.sv @@
// Shared add/subtract unit; on subtract, carry high means no borrow.
module gla_alu (
  input  gla_pkg::alu_req_t req_i,
  output gla_pkg::alu_rsp_t rsp_o
);

  logic [gla_pkg::MULT_BITS-1:0] rhs_eff;
  logic [gla_pkg::MULT_BITS:0]   total;

  always_comb begin
    rhs_eff = req_i.sub ? ~req_i.rhs : req_i.rhs;
    total   = {1'b0, req_i.lhs} + {1'b0, rhs_eff} + {{gla_pkg::MULT_BITS{1'b0}}, req_i.sub};
    rsp_o.sum   = total[gla_pkg::MULT_BITS-1:0];
    rsp_o.carry = total[gla_pkg::MULT_BITS];
  end

endmodule

@@ dv/tb.sv @@
// Testbench for gcd_lcm_by_factorization: directed and random pairs, scored by table or predictor.
`timescale 1ns / 100ps

module tb;

  localparam int OPERAND_BITS = gla_pkg::OPERAND_BITS;
  localparam int MULT_BITS    = gla_pkg::MULT_BITS;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned NUM_VECTORS = 23;
  localparam int unsigned NUM_RANDOM  = 1950;
  localparam logic [OPERAND_BITS-1:0] TOP_OPERAND = '1;

  typedef struct packed {
    gla_pkg::in_beat_t  stim;
    logic               typed;  // want holds the expected beat; else the predictor supplies it
    gla_pkg::out_beat_t want;
  } vector_row_t;

  localparam gla_pkg::out_beat_t REJECTED =
    '{common_divisor: '0, common_multiple: '0, input_error: 1'b1};
  localparam gla_pkg::out_beat_t UNTYPED  = '0;

  vector_row_t vectors [NUM_VECTORS] = '{
    '{'{31'd0, 31'd0}, 1'b1, REJECTED},
    '{'{31'd0, 31'd7}, 1'b1, REJECTED},
    '{'{31'd1, 31'd1}, 1'b1, REJECTED},
    '{'{31'd5, 31'd1}, 1'b1, REJECTED},
    '{'{31'd1, TOP_OPERAND}, 1'b1, REJECTED},
    '{'{TOP_OPERAND, 31'd0}, 1'b1, REJECTED},
    '{'{31'd2, 31'd2}, 1'b1, '{31'd2, 62'd2, 1'b0}},
    '{'{31'd2, 31'd3}, 1'b1, '{31'd1, 62'd6, 1'b0}},
    '{'{TOP_OPERAND, TOP_OPERAND}, 1'b1, '{TOP_OPERAND, 62'(TOP_OPERAND), 1'b0}},
    '{'{TOP_OPERAND, TOP_OPERAND - 31'd1}, 1'b1, '{31'd1, 62'd4611686011984936962, 1'b0}},
    '{'{31'd1073741824, 31'd1073741824}, 1'b1, '{31'd1073741824, 62'd1073741824, 1'b0}},
    '{'{31'd1073741824, 31'd2}, 1'b1, '{31'd2, 62'd1073741824, 1'b0}},
    '{'{31'd2, 31'd1073741824}, 1'b1, '{31'd2, 62'd1073741824, 1'b0}},
    '{'{TOP_OPERAND, 31'd2}, 1'b1, '{31'd1, 62'd4294967294, 1'b0}},
    '{'{31'd2, TOP_OPERAND}, 1'b1, '{31'd1, 62'd4294967294, 1'b0}},
    '{'{31'd1073741824, 31'd1162261467}, 1'b0, UNTYPED},
    '{'{31'd12, 31'd18}, 1'b0, UNTYPED},
    '{'{31'd1024, 31'd48}, 1'b0, UNTYPED},
    '{'{31'd2147483646, 31'd1073741823}, 1'b0, UNTYPED},
    '{'{31'd999983, 31'd1999966}, 1'b0, UNTYPED},
    '{'{31'd46340, 31'd46341}, 1'b0, UNTYPED},
    '{'{31'd30030, 31'd510510}, 1'b0, UNTYPED},
    '{'{31'd65536, 31'd65537}, 1'b0, UNTYPED}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  gla_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  gla_pkg::out_beat_t out_data_o;

  gla_pkg::out_beat_t pending_results [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;  // no gaps or stalls on either side
  bit          out_seen    = 1'b0;

  gcd_lcm_by_factorization dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic gla_pkg::out_beat_t gcd_lcm_of(input gla_pkg::in_beat_t beat);
    logic [OPERAND_BITS-1:0] x;
    logic [OPERAND_BITS-1:0] y;
    logic [OPERAND_BITS-1:0] rem;
    gla_pkg::out_beat_t res;
    res = '0;
    if (beat.first_value < gla_pkg::MinValid || beat.second_value < gla_pkg::MinValid) begin
      res.input_error = 1'b1;
      return res;
    end
    x = beat.first_value;
    y = beat.second_value;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    res.common_divisor  = x;
    res.common_multiple = MULT_BITS'(beat.first_value / x) * MULT_BITS'(beat.second_value);
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic gla_pkg::in_beat_t random_pair();
    int unsigned pick;
    int unsigned g;
    gla_pkg::in_beat_t beat;
    pick = $urandom_range(0, 99);
    beat.first_value  = OPERAND_BITS'($urandom());
    beat.second_value = OPERAND_BITS'($urandom());
    if (pick < 4) begin
      if ($urandom_range(0, 1) == 1) beat.first_value = OPERAND_BITS'($urandom_range(0, 1));
      else beat.second_value = OPERAND_BITS'($urandom_range(0, 1));
    end else if (pick < 30) begin
      // full-range operands as drawn
    end else if (pick < 55) begin
      // shared factor of widely varying size
      g = $urandom_range(2, 1 << $urandom_range(1, 20));
      beat.first_value  = OPERAND_BITS'(g * $urandom_range(1, 32'(TOP_OPERAND) / g));
      beat.second_value = OPERAND_BITS'(g * $urandom_range(1, 32'(TOP_OPERAND) / g));
    end else if (pick < 68) begin
      beat.first_value  = OPERAND_BITS'($urandom_range(2, 64));
      beat.second_value = OPERAND_BITS'($urandom_range(2, 64));
    end else if (pick < 78) begin
      beat.first_value  = OPERAND_BITS'(1) << $urandom_range(1, 30);
      beat.second_value = OPERAND_BITS'(1) << $urandom_range(1, 30);
    end else if (pick < 88) begin
      beat.first_value  = TOP_OPERAND - OPERAND_BITS'($urandom_range(0, 1023));
      beat.second_value = TOP_OPERAND - OPERAND_BITS'($urandom_range(0, 1023));
    end else begin
      beat.second_value = beat.first_value >> $urandom_range(0, 30);
    end
    return beat;
  endfunction

  // Called right after a posedge; returns after the accepting posedge and any random idle gap.
  task automatic send_pair(input gla_pkg::in_beat_t beat, input logic typed,
                           input gla_pkg::out_beat_t want);
    bit fire;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(negedge clk_i);
      fire = !in_stall_o;
      @(posedge clk_i);
    end while (!fire);
    pending_results.push_back(typed ? want : gcd_lcm_of(beat));
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sample at the falling edge: a beat seen here is taken at the next rising edge.
  always @(negedge clk_i) begin
    gla_pkg::out_beat_t want;
    out_seen <= out_valid_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending expectation");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.common_divisor !== want.common_divisor) begin
          $error("common_divisor: expected %0d, got %0d",
                 want.common_divisor, out_data_o.common_divisor);
          mismatches++;
        end
        if (out_data_o.common_multiple !== want.common_multiple) begin
          $error("common_multiple: expected %0d, got %0d",
                 want.common_multiple, out_data_o.common_multiple);
          mismatches++;
        end
        if (out_data_o.input_error !== want.input_error) begin
          $error("input_error: expected %0d, got %0d",
                 want.input_error, out_data_o.input_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      // stall more eagerly while a result is waiting
      if (hold == 0 && !calm && $urandom_range(0, out_seen ? 3 : 11) == 0) begin
        hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      send_pair(vectors[i].stim, vectors[i].typed, vectors[i].want);
    end
    drain_results();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 250 == 0) calm = ((n / 250) % 3 == 2);
      if (n == NUM_RANDOM / 2) drain_results();
      send_pair(random_pair(), 1'b0, UNTYPED);
    end

    drain_results();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ gcd_lcm_by_factorization.f @@
+incdir+hdl
hdl/gla_pkg.sv
hdl/gla_alu.sv
hdl/gcd_lcm_by_factorization.sv
dv/tb.sv
